// ===== rtl/dtet_pkg.sv =====
// Shared types and constants for the deadline timer event table.
package dtet_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TPS_W       = 10;
  localparam logic [TPS_W-1:0] TPS_RESET = 10'd32;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_TPS = 1'b0;

  // Result kinds and actions.
  localparam logic [1:0] KIND_ADDED   = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_WAKE    = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [7:0] ACTION_WAKE  = 8'd0;

  // Millisecond to tick conversion: the 42-bit product is divided by 1000
  // one byte at a time, each byte step using an exact reciprocal multiply.
  localparam int MS_PER_SEC  = 1000;
  localparam int PROD_W      = 42;
  localparam int CHUNK_W     = 8;
  localparam int DIV_STEPS   = 6;
  localparam int PBUF_W      = CHUNK_W * DIV_STEPS;
  localparam int REM_W       = 10;
  localparam int V_W         = REM_W + CHUNK_W;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_M = 19'd268436;
  localparam int VM_W        = V_W + RECIP_W;

  // Slot memory word: deadline, action, thread.
  localparam int DL_W   = 32;
  localparam int ACT_W  = 8;
  localparam int THR_W  = 16;
  localparam int SLOT_W = DL_W + ACT_W + THR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_COMMIT,
    ST_TICK,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div_step;
    logic add_commit;
    logic tick;
    logic scan;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_tick;
    logic div_last;
    logic out_free;
    logic scan_end;
    logic pend_valid;
  } dp_sts_t;

endpackage

// ===== rtl/dtet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dtet_ctrl.sv =====
// Controller state machine for the deadline timer event table.
module dtet_ctrl import dtet_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        // The captured command picks the add path or the tick path.
        if (sts.item_tick) begin
          state_next = ST_TICK;
        end else begin
          ctl.mul    = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          ctl.add_commit = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_TICK: begin
        ctl.tick   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          ctl.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dtet_dp.sv =====
// Datapath: tick counter, slot table, deadline divider, scan and output stage.
module dtet_dp import dtet_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          ctl,
  output dp_sts_t            sts,
  input  logic               cmd,
  input  logic [31:0]        delay_ms,
  input  logic [ACT_W-1:0]   action_code,
  input  logic [THR_W-1:0]   thread_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [THR_W-1:0]   woken_thread,
  output logic [ACT_W-1:0]   expired_action,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW   = $clog2(MAX_RESULTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  // Configuration register.
  logic [TPS_W-1:0] tps;

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (psel && penable && pwrite && (paddr[2:2] == REG_TPS)) begin
      tps <= pwdata[TPS_W-1:0];
    end
  end

  assign prdata = (paddr[2:2] == REG_TPS) ? PDATA_W'(tps) : '0;

  // Captured item.
  logic             item_cmd;
  logic [31:0]      item_delay;
  logic [ACT_W-1:0] item_action;
  logic [THR_W-1:0] item_thread;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd    <= cmd;
      item_delay  <= delay_ms;
      item_action <= action_code;
      item_thread <= thread_number;
    end
  end

  // Millisecond conversion: product, then six byte steps of division by 1000.
  logic [PROD_W-1:0] mprod;
  logic [PBUF_W-1:0] prod;
  logic [DL_W-1:0]   quo;
  logic [REM_W-1:0]  rem;
  logic [2:0]        div_cnt;
  logic [V_W-1:0]    v;
  logic [VM_W-1:0]   vm;
  logic [CHUNK_W-1:0] qd;
  logic [V_W-1:0]    q1000;
  logic [V_W-1:0]    rem_full;

  assign mprod    = item_delay * tps;
  assign v        = {rem, prod[PBUF_W-1 -: CHUNK_W]};
  assign vm       = v * RECIP_M;
  assign qd       = vm[RECIP_SHIFT +: CHUNK_W];
  // qd * 1000 = qd * 1024 - qd * 16 - qd * 8
  assign q1000    = (V_W'(qd) << 10) - (V_W'(qd) << 4) - (V_W'(qd) << 3);
  assign rem_full = v - q1000;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod    <= PBUF_W'(mprod);
      quo     <= '0;
      rem     <= '0;
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      prod    <= prod << CHUNK_W;
      quo     <= {quo[DL_W-CHUNK_W-1:0], qd};
      rem     <= rem_full[REM_W-1:0];
      div_cnt <= div_cnt + 3'd1;
    end
  end

  // Tick counter and valid marks.
  logic [DL_W-1:0]  tick_count;
  logic [SLOTS-1:0] slot_valid;
  logic             free_found;
  logic [IDXW-1:0]  free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDXW'(i);
      end
    end
  end

  // Slot memory.
  logic              ram_we;
  logic [IDXW-1:0]   ram_raddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  logic [DL_W-1:0]   deadline;

  assign deadline  = tick_count + quo + 32'd1;
  assign ram_we    = ctl.add_commit && free_found;
  assign ram_wdata = {deadline, item_action, item_thread};

  // Scan state. The read address runs one slot ahead of the slot being checked.
  logic              out_free;
  logic [IDXW-1:0]   rd_idx;
  logic              rd_done;
  logic [IDXW-1:0]   chk_idx;
  logic              chk_valid;
  logic [NW-1:0]     n_found;
  logic              pend_valid;
  logic [1:0]        pend_kind;
  logic [ACT_W-1:0]  pend_action;
  logic [THR_W-1:0]  pend_thread;
  logic [DL_W-1:0]   rd_deadline;
  logic [ACT_W-1:0]  rd_action;
  logic [THR_W-1:0]  rd_thread;
  logic              hit;
  logic              stall;
  logic              cap_hit;

  assign out_free = !out_valid || out_ready;
  assign {rd_deadline, rd_action, rd_thread} = ram_rdata;

  assign cap_hit = (n_found == NW'(MAX_RESULTS));
  assign hit     = ctl.scan && chk_valid && slot_valid[chk_idx] &&
                   (rd_deadline <= tick_count) && !cap_hit;
  // A new hit must push the previous one out; that waits for a free output.
  assign stall   = hit && pend_valid && !out_free;

  assign ram_raddr = stall ? chk_idx : rd_idx;

  dtet_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS),
    .AW    (IDXW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      slot_valid <= '0;
      rd_idx     <= '0;
      rd_done    <= 1'b0;
      chk_idx    <= '0;
      chk_valid  <= 1'b0;
      n_found    <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (ctl.tick) begin
        tick_count <= tick_count + 32'd1;
        rd_idx     <= '0;
        rd_done    <= 1'b0;
        chk_valid  <= 1'b0;
        n_found    <= '0;
        pend_valid <= 1'b0;
      end else if (ctl.scan && !stall) begin
        chk_idx   <= rd_idx;
        chk_valid <= !rd_done;
        if (rd_idx == LAST_IDX) begin
          rd_done <= 1'b1;
        end else begin
          rd_idx <= rd_idx + IDXW'(1);
        end
        if (hit) begin
          slot_valid[chk_idx] <= 1'b0;
          n_found             <= n_found + NW'(1);
          pend_valid          <= 1'b1;
        end
      end else if (ctl.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && !stall) begin
      pend_kind   <= (rd_action == ACTION_WAKE) ? KIND_WAKE : KIND_UNKNOWN;
      pend_action <= rd_action;
      pend_thread <= rd_thread;
    end
  end

  // Output register.
  logic push_pend;

  assign push_pend = (hit && !stall && pend_valid) || ctl.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.add_commit || push_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add_commit) begin
      kind           <= free_found ? KIND_ADDED : KIND_FULL;
      woken_thread   <= '0;
      expired_action <= '0;
      last           <= 1'b1;
    end else if (push_pend) begin
      kind           <= pend_kind;
      woken_thread   <= pend_thread;
      expired_action <= pend_action;
      last           <= ctl.flush;
    end
  end

  // Status to the controller.
  assign sts.item_tick  = item_cmd;
  assign sts.div_last   = (div_cnt == 3'(DIV_STEPS - 1));
  assign sts.out_free   = out_free;
  assign sts.scan_end   = cap_hit || (chk_valid && (chk_idx == LAST_IDX) && !stall);
  assign sts.pend_valid = pend_valid;

endmodule

// ===== rtl/deadline_timer_event_table_top.sv =====
// Top level of the deadline timer event table.
// An add transaction runs through the product, six divide-by-1000 byte steps and
// a commit that waits for a free output and presents the result; the next
// transaction is accepted after the commit.
// A tick transaction runs from acceptance through decode, counter update, a scan
// of one slot per cycle through the registered slot memory read port, held while
// the output is stalled, which ends at the last slot or at 16 results, and a flush
// of the final result when one is pending. One transaction is in flight at a time.
// Synchronous reset clears the valid marks, the tick counter and the rate
// register (to 32); slot contents are not cleared.
module deadline_timer_event_table_top import dtet_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [31:0]        delay_ms,
  input  logic [ACT_W-1:0]   action_code,
  input  logic [THR_W-1:0]   thread_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [THR_W-1:0]   woken_thread,
  output logic [ACT_W-1:0]   expired_action,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ctrl_cmd_t ctl;
  dp_sts_t   sts;

  assign pready = 1'b1;

  dtet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  dtet_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .cmd            (cmd),
    .delay_ms       (delay_ms),
    .action_code    (action_code),
    .thread_number  (thread_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .woken_thread   (woken_thread),
    .expired_action (expired_action),
    .last           (last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
  );

endmodule

// ===== rtl/dtet_checker.sv =====
// Port-level assertions for the deadline timer event table, bound to the top.
module dtet_checker import dtet_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [THR_W-1:0]   woken_thread,
  input logic [ACT_W-1:0]   expired_action,
  input logic               last,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(kind) && $stable(woken_thread) &&
       $stable(expired_action) && $stable(last)))
    else $error("result changed while stalled");

  // After a transaction is accepted the block is not ready in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Add results are single and carry no thread or action.
  a_add_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_ADDED || kind == KIND_FULL)) |->
      (last && woken_thread == '0 && expired_action == '0))
    else $error("malformed add result");

  // The expiry kind agrees with the action code it reports.
  a_kind_action: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_WAKE || kind == KIND_UNKNOWN)) |->
      ((kind == KIND_WAKE) == (expired_action == ACTION_WAKE)))
    else $error("expiry kind does not match action");

  // A written rate reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2] == REG_TPS) |=>
      (paddr[2] != REG_TPS || prdata[TPS_W-1:0] == $past(pwdata[TPS_W-1:0])))
    else $error("rate register readback mismatch");

endmodule

bind deadline_timer_event_table_top dtet_checker u_dtet_checker (.*);
